// ===== hw/rtl/atg_pkg.sv =====
package atg_pkg;

  localparam int CHORD_NOTES     = 3;
  localparam int CHORD_COUNT     = 4;
  localparam int ENV_LUT_DEPTH   = 1024;
  localparam int PHASE_BITS      = 32;

  localparam int NOTE_BITS   = 2;
  localparam int CHORD_BITS  = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int ENV_BITS    = 15;
  localparam int AMP_BITS    = 15;
  localparam int STEP_BITS   = 32;
  localparam int CFG_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;

  localparam int ENV_IDX_BITS  = $clog2(ENV_LUT_DEPTH);
  localparam int ENV_ROM_DEPTH = ENV_LUT_DEPTH / 2 + 1;
  localparam int ENV_ADDR_BITS = $clog2(ENV_ROM_DEPTH);

  // Pending request queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_NOTE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENVELOPE_STEP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE     = 2'd2;

  localparam logic [COUNT_BITS-1:0] NOTE_LENGTH_RESET   = 16'd14700;
  localparam logic [STEP_BITS-1:0]  ENVELOPE_STEP_RESET = 32'd292171;
  localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET     = 15'd9000;

  typedef struct packed {
    logic [COUNT_BITS-1:0] note_length;
    logic [STEP_BITS-1:0]  envelope_step;
    logic [AMP_BITS-1:0]   amplitude;
  } cfg_t;

  typedef logic [31:0] note_inc_t [CHORD_COUNT][CHORD_NOTES];

  // Phase increments, round(f / 44100 * 2^32): Am, Em, F and C triads.
  localparam note_inc_t NOTE_INC = '{
    '{32'd10713070, 32'd12739788, 32'd16051101},
    '{32'd16051101, 32'd19088744, 32'd24049869},
    '{32'd17005538, 32'd21426141, 32'd25480551},
    '{32'd12739788, 32'd16051101, 32'd19088744}
  };

  typedef logic [ENV_BITS-1:0] env_rom_t [ENV_ROM_DEPTH];

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Rising half of the half-sine, Q0.15, from a Q30 Taylor series.
  // The falling half is read by mirroring the index.
  function automatic env_rom_t build_env_rom();
    env_rom_t    rom;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    for (int u = 0; u < ENV_ROM_DEPTH; u++) begin
      a  = (PI_Q30 * 64'(u)) / 64'(ENV_LUT_DEPTH);
      a2 = (a * a) >> 30;
      t  = ONE_Q30 - a2 / 64'd110;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
      s  = (a * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      rom[u] = (s > 64'd32767) ? 15'd32767 : s[ENV_BITS-1:0];
    end
    return rom;
  endfunction

  localparam env_rom_t ENV_ROM = build_env_rom();

endpackage

// ===== hw/rtl/atg_if.sv =====
interface atg_req_if;
  logic valid;
  logic ready;
  logic sample_request;

  modport source (output valid, output sample_request, input ready);
  modport sink (input valid, input sample_request, output ready);
endinterface

interface atg_smp_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [atg_pkg::SAMPLE_BITS-1:0]     sample;
  logic        [atg_pkg::CHORD_BITS-1:0]      chord_number;
  logic        [atg_pkg::NOTE_BITS-1:0]       note_number;

  modport source (output valid, output sample, output chord_number, output note_number,
                  input ready);
  modport sink (input valid, input sample, input chord_number, input note_number,
                output ready);
endinterface

// ===== hw/rtl/atg_front.sv =====
module atg_front (
  input  logic       clk,
  input  logic       rst,
  atg_req_if.sink    req,
  input  logic       pop,
  output logic       pending
);

  logic [atg_pkg::QUEUE_BITS-1:0] count;
  logic [atg_pkg::QUEUE_BITS-1:0] count_next;
  logic                           push;

  // A request with the request bit clear is taken but never queued.
  assign req.ready = (count != atg_pkg::QUEUE_BITS'(atg_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready && req.sample_request;
  assign pending   = (count != '0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/atg_back.sv =====
module atg_back (
  input  logic          clk,
  input  logic          rst,
  input  atg_pkg::cfg_t cfg,
  input  logic          pending,
  output logic          pop,
  atg_smp_if.source     smp
);

  // Generator state
  logic [atg_pkg::PHASE_BITS-1:0] osc_phase;
  logic [atg_pkg::STEP_BITS-1:0]  env_phase;
  logic [atg_pkg::COUNT_BITS-1:0] note_sample_count;
  logic [atg_pkg::NOTE_BITS-1:0]  current_note;
  logic [atg_pkg::CHORD_BITS-1:0] current_chord;

  logic [atg_pkg::PHASE_BITS-1:0] osc_phase_next;
  logic [atg_pkg::STEP_BITS-1:0]  env_phase_next;
  logic [atg_pkg::COUNT_BITS-1:0] note_sample_count_next;
  logic [atg_pkg::NOTE_BITS-1:0]  current_note_next;
  logic [atg_pkg::CHORD_BITS-1:0] current_chord_next;

  // Pipeline registers
  logic                            s1_valid;
  logic [atg_pkg::ENV_BITS-1:0]    s1_env;
  logic [15:0]                     s1_mag;
  logic                            s1_neg;
  logic [atg_pkg::CHORD_BITS-1:0]  s1_chord;
  logic [atg_pkg::NOTE_BITS-1:0]   s1_note;

  logic                            s2_valid;
  logic [30:0]                     s2_prod;
  logic                            s2_neg;
  logic [atg_pkg::CHORD_BITS-1:0]  s2_chord;
  logic [atg_pkg::NOTE_BITS-1:0]   s2_note;

  logic                            out_valid;
  logic [atg_pkg::SAMPLE_BITS-1:0] out_sample;
  logic [atg_pkg::CHORD_BITS-1:0]  out_chord;
  logic [atg_pkg::NOTE_BITS-1:0]   out_note;

  logic out_free;
  logic s2_free;
  logic s1_free;
  logic start;

  logic [15:0]                      tri_x;
  logic signed [17:0]               tri_d;
  logic signed [17:0]               tri_ad;
  logic signed [17:0]               tri_v;
  logic signed [17:0]               tri_av;
  logic                             tri_neg;
  logic [15:0]                      tri_mag;
  logic [atg_pkg::ENV_IDX_BITS-1:0] env_idx;
  logic [atg_pkg::ENV_IDX_BITS:0]   env_mirror;
  logic [atg_pkg::ENV_ADDR_BITS-1:0] env_addr;
  logic [atg_pkg::PHASE_BITS-1:0]   note_inc;
  logic [atg_pkg::COUNT_BITS-1:0]   count_inc;
  logic                             note_end;
  logic [45:0]                      full_prod;
  logic [15:0]                      res_mag;

  assign out_free = !out_valid || smp.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign start    = pending && s1_free;
  assign pop      = start;

  // Triangle from the top 16 phase bits; only the positive peak saturates.
  always_comb begin
    tri_x   = osc_phase[atg_pkg::PHASE_BITS-1 -: 16];
    tri_d   = $signed({2'b00, tri_x}) - 18'sd32768;
    tri_ad  = (tri_d < 0) ? -tri_d : tri_d;
    tri_v   = (tri_ad <<< 1) - 18'sd32768;
    tri_neg = (tri_v < 0);
    tri_av  = tri_neg ? -tri_v : tri_v;
    if (!tri_neg && tri_v > 18'sd32767) begin
      tri_mag = 16'd32767;
    end else begin
      tri_mag = tri_av[15:0];
    end
  end

  // The table holds the rising half only; the falling half mirrors it.
  always_comb begin
    env_idx    = env_phase[atg_pkg::STEP_BITS-1 -: atg_pkg::ENV_IDX_BITS];
    env_mirror = (atg_pkg::ENV_IDX_BITS+1)'(atg_pkg::ENV_LUT_DEPTH) - {1'b0, env_idx};
    if ({1'b0, env_idx} <= (atg_pkg::ENV_IDX_BITS+1)'(atg_pkg::ENV_LUT_DEPTH / 2)) begin
      env_addr = atg_pkg::ENV_ADDR_BITS'(env_idx);
    end else begin
      env_addr = atg_pkg::ENV_ADDR_BITS'(env_mirror);
    end
  end

  always_comb begin
    note_inc  = atg_pkg::PHASE_BITS'(atg_pkg::NOTE_INC[current_chord][current_note]
                                     >> (32 - atg_pkg::PHASE_BITS));
    count_inc = note_sample_count + 1'b1;
    // A count that wraps to zero also ends the note; a length of zero acts as one.
    note_end  = (count_inc >= cfg.note_length) || (count_inc == '0);

    osc_phase_next         = osc_phase + note_inc;
    env_phase_next         = env_phase + cfg.envelope_step;
    note_sample_count_next = count_inc;
    current_note_next      = current_note;
    current_chord_next     = current_chord;
    if (note_end) begin
      note_sample_count_next = '0;
      env_phase_next         = '0;
      if (current_note == atg_pkg::NOTE_BITS'(atg_pkg::CHORD_NOTES - 1)) begin
        current_note_next = '0;
        if (current_chord == atg_pkg::CHORD_BITS'(atg_pkg::CHORD_COUNT - 1)) begin
          current_chord_next = '0;
        end else begin
          current_chord_next = current_chord + 1'b1;
        end
      end else begin
        current_note_next = current_note + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_phase         <= '0;
      env_phase         <= '0;
      note_sample_count <= '0;
      current_note      <= '0;
      current_chord     <= '0;
    end else if (start) begin
      osc_phase         <= osc_phase_next;
      env_phase         <= env_phase_next;
      note_sample_count <= note_sample_count_next;
      current_note      <= current_note_next;
      current_chord     <= current_chord_next;
    end
  end

  // Envelope table read, registered.
  always_ff @(posedge clk) begin
    if (start) begin
      s1_env   <= atg_pkg::ENV_ROM[env_addr];
      s1_mag   <= tri_mag;
      s1_neg   <= tri_neg;
      s1_chord <= current_chord;
      s1_note  <= current_note;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2_prod  <= {15'd0, s1_mag} * {16'd0, s1_env};
      s2_neg   <= s1_neg;
      s2_chord <= s1_chord;
      s2_note  <= s1_note;
    end
  end

  assign full_prod = {15'd0, s2_prod} * {31'd0, cfg.amplitude};
  assign res_mag   = full_prod[45:30];

  always_ff @(posedge clk) begin
    if (s2_valid && out_free) begin
      out_sample <= s2_neg ? 16'(16'd0 - res_mag) : res_mag;
      out_chord  <= s2_chord;
      out_note   <= s2_note;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= start;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  assign smp.valid        = out_valid;
  assign smp.sample       = $signed(out_sample);
  assign smp.chord_number = out_chord;
  assign smp.note_number  = out_note;

endmodule

// ===== hw/rtl/arpeggio_tone_generator_top.sv =====
// A queued request is taken by the back end and its sample passes through the s1, s2 and
// output registers. Throughput: one sample per cycle sustained while smp.ready is high;
// the phase and note counters update in the cycle in which the back end takes a request.
// Up to two requests queue between the front end and the back end.
// Reset (rst, synchronous): config registers return to their defaults; phases, counters and the queue clear.
module arpeggio_tone_generator_top (
  input  logic                               clk,
  input  logic                               rst,
  atg_req_if.sink                            req,
  atg_smp_if.source                          smp,
  input  logic                               cfg_we,
  input  logic [atg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [atg_pkg::CFG_BITS-1:0]       cfg_data
);

  atg_pkg::cfg_t cfg;
  logic          pending;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.note_length   <= atg_pkg::NOTE_LENGTH_RESET;
      cfg.envelope_step <= atg_pkg::ENVELOPE_STEP_RESET;
      cfg.amplitude     <= atg_pkg::AMPLITUDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atg_pkg::REG_NOTE_LENGTH: begin
          cfg.note_length <= cfg_data[atg_pkg::COUNT_BITS-1:0];
        end
        atg_pkg::REG_ENVELOPE_STEP: begin
          cfg.envelope_step <= cfg_data[atg_pkg::STEP_BITS-1:0];
        end
        atg_pkg::REG_AMPLITUDE: begin
          cfg.amplitude <= cfg_data[atg_pkg::AMP_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  atg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .pop     (pop),
    .pending (pending)
  );

  atg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pending (pending),
    .pop     (pop),
    .smp     (smp)
  );

endmodule
